// ----- sv/ggs4_pkg.sv -----
`default_nettype none
package ggs4_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int RES_DEPTH = 8;

    localparam logic [6:0] SIZE_RST = 7'd64;
    localparam logic LATTICE_RST = 1'b0;
    localparam logic [31:0] SCALE_RST = 32'h0100_0000;

    typedef enum logic [2:0] {
        CFG_SIZE_X  = 3'd0,
        CFG_SIZE_Y  = 3'd1,
        CFG_SIZE_Z  = 3'd2,
        CFG_LATTICE = 3'd3,
        CFG_SCALE_X = 3'd4,
        CFG_SCALE_Y = 3'd5,
        CFG_SCALE_Z = 3'd6
    } cfg_index_t;

    // One store word: the four most recent x planes at one (y, z) spot.
    typedef logic [3:0][31:0] quad_t;
    // Four consecutive rows of store words at one z column.
    typedef logic [3:0][3:0][31:0] hist_t;
    // Five rows of store words at one z column, row 0 is the newest.
    typedef logic [4:0][3:0][31:0] col_t;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/grid_gradient_stencil_4th_order.sv -----
`default_nettype none
// Throughput: one sample per cycle; the input stalls only while 8 results are owed downstream.
// Each sample does one read-ahead of the plane store and one of the column history store.
// Reset clears the position counters, pipeline tokens and result queue, and loads the
// register defaults; the stores are not cleared and hold whatever they held before.
module grid_gradient_stencil_4th_order
    import ggs4_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [31:0] sample,
    output logic                    grad_valid,
    input  wire logic               grad_stall,
    output logic signed [31:0]      grad_x,
    output logic signed [31:0]      grad_y,
    output logic signed [31:0]      grad_z,
    output logic                    last_point
);

    localparam int SPAN = MAX_DIM + 4;
    localparam int DW = $clog2(MAX_DIM + 5);
    localparam int KW = (DW > 7) ? DW : 7;
    localparam int AW = $clog2(SPAN * SPAN);
    localparam int ZW = $clog2(SPAN);
    localparam int CW = $clog2(RES_DEPTH + 1);
    localparam int FW = $clog2(RES_DEPTH);

    function automatic logic [DW-1:0] extent(input logic [6:0] s);
        logic [KW-1:0] v;
        begin
            v = KW'(s);
            if (v == '0)
                v = KW'(1);
            else if (v > KW'(MAX_DIM))
                v = KW'(MAX_DIM);
            extent = DW'(v + KW'(4));
        end
    endfunction

    function automatic logic signed [36:0] stencil(
        input logic [31:0] m2, input logic [31:0] m1a, input logic [31:0] m1b,
        input logic [31:0] p1a, input logic [31:0] p1b, input logic [31:0] p2);
        logic signed [36:0] a;
        logic signed [36:0] b;
        logic signed [36:0] c;
        logic signed [36:0] d;
        logic signed [36:0] e;
        logic signed [36:0] f;
        begin
            a = {{5{m2[31]}}, m2};
            b = {{5{m1a[31]}}, m1a};
            c = {{5{m1b[31]}}, m1b};
            d = {{5{p1a[31]}}, p1a};
            e = {{5{p1b[31]}}, p1b};
            f = {{5{p2[31]}}, p2};
            stencil = a - ((b + c) <<< 2) + ((d + e) <<< 2) - f;
        end
    endfunction

    // Configuration registers
    logic [6:0]  size_x_reg, size_y_reg, size_z_reg;
    logic        lattice_reg;
    logic [31:0] scale_x_reg, scale_y_reg, scale_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg  <= SIZE_RST;
            size_y_reg  <= SIZE_RST;
            size_z_reg  <= SIZE_RST;
            lattice_reg <= LATTICE_RST;
            scale_x_reg <= SCALE_RST;
            scale_y_reg <= SCALE_RST;
            scale_z_reg <= SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE_X:  size_x_reg  <= cfg_data[6:0];
                CFG_SIZE_Y:  size_y_reg  <= cfg_data[6:0];
                CFG_SIZE_Z:  size_z_reg  <= cfg_data[6:0];
                CFG_LATTICE: lattice_reg <= cfg_data[0];
                CFG_SCALE_X: scale_x_reg <= cfg_data;
                CFG_SCALE_Y: scale_y_reg <= cfg_data;
                CFG_SCALE_Z: scale_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic [DW-1:0] ex, ey, ez;
    assign ex = extent(size_x_reg);
    assign ey = extent(size_y_reg);
    assign ez = extent(size_z_reg);

    // Raster position and read-ahead address
    logic [DW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [DW-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [DW-1:0] z_inc, y_inc, x_inc;
    logic [DW:0]   ra_y, ra_z;
    logic          acc, interior, last_here;
    logic [AW-1:0] wr_addr, rd_addr;

    assign acc = sample_valid && !sample_stall;

    assign interior = (pos_x_reg >= DW'(4)) && (pos_x_reg < ex)
                   && (pos_y_reg >= DW'(2)) && (pos_y_reg < ey - DW'(2))
                   && (pos_z_reg >= DW'(2)) && (pos_z_reg < ez - DW'(2));
    assign last_here = (pos_x_reg == ex - DW'(1)) && (pos_y_reg == ey - DW'(3))
                    && (pos_z_reg == ez - DW'(3));

    always_comb
    begin
        z_inc = pos_z_reg + DW'(1);
        y_inc = pos_y_reg + DW'(1);
        x_inc = pos_x_reg + DW'(1);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = z_inc;
        if (z_inc >= ez)
        begin
            pos_z_next = '0;
            pos_y_next = y_inc;
            if (y_inc >= ey)
            begin
                pos_y_next = '0;
                pos_x_next = (x_inc >= ex) ? '0 : x_inc;
            end
        end
    end

    // The word read now is the one two rows and two samples ahead in the stream.
    always_comb
    begin
        ra_z = {1'b0, pos_z_reg} + (DW+1)'(2);
        ra_y = {1'b0, pos_y_reg} + (DW+1)'(2);
        if (ra_z >= {1'b0, ez})
        begin
            ra_z = ra_z - {1'b0, ez};
            ra_y = ra_y + (DW+1)'(1);
        end
        if (ra_y >= {1'b0, ey})
            ra_y = ra_y - {1'b0, ey};
    end

    assign wr_addr = AW'(pos_y_reg) * AW'(SPAN) + AW'(pos_z_reg);
    assign rd_addr = AW'(ra_y[DW-1:0]) * AW'(SPAN) + AW'(ra_z[DW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (acc)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    // Plane store: slot x mod 4 of each word holds plane x.
    quad_t plane_mem [SPAN*SPAN];
    quad_t plane_rd_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            plane_mem[wr_addr][pos_x_reg[1:0]] <= sample;
            plane_rd_reg <= plane_mem[rd_addr];
        end
    end

    // Column history: the four rows that passed each z column before the current one.
    hist_t          hist_mem [SPAN];
    hist_t          hist_rd_reg;
    logic [ZW-1:0]  hz_reg;
    logic           a1_reg;
    col_t           col_cur;

    assign col_cur = col_t'({hist_rd_reg, plane_rd_reg});

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            hist_rd_reg <= hist_mem[ra_z[ZW-1:0]];
            hz_reg <= ra_z[ZW-1:0];
        end
        if (a1_reg)
            hist_mem[hz_reg] <= col_cur[3:0];
    end

    // Stage 1: pick the stencil taps out of the current and earlier columns.
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [1:0]         slot1_reg;
    logic               hex1_reg;
    logic               last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;
    logic [31:0]        smp1_reg;
    col_t               col1_reg, col2_reg;
    quad_t              row3_reg, row4_reg;
    logic [1:0]         sm1, sm2, sm3;
    quad_t              opx, opz;
    logic [5:0][31:0]   opy;
    quad_t              opx_reg, opz_reg;
    logic [5:0][31:0]   opy_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            slot1_reg <= pos_x_reg[1:0];
            hex1_reg <= lattice_reg;
            last1_reg <= last_here;
            smp1_reg <= sample;
        end
        if (a1_reg)
        begin
            col1_reg <= col_cur;
            col2_reg <= col1_reg;
            row3_reg <= col2_reg[2];
            row4_reg <= row3_reg;
        end
    end

    always_comb
    begin
        sm1 = slot1_reg - 2'd1;
        sm2 = slot1_reg + 2'd2;
        sm3 = slot1_reg + 2'd1;
        opx[3] = col2_reg[2][slot1_reg];
        opx[2] = col2_reg[2][sm3];
        opx[1] = col2_reg[2][sm1];
        opx[0] = smp1_reg;
        opz[3] = row4_reg[sm2];
        opz[2] = row3_reg[sm2];
        opz[1] = col1_reg[2][sm2];
        opz[0] = col_cur[2][sm2];
        // The hexagonal stencil leans on the neighboring planes; cubic uses the center plane.
        opy[5] = hex1_reg ? col2_reg[4][sm1] : col2_reg[4][sm2];
        opy[4] = hex1_reg ? col2_reg[3][sm1] : col2_reg[3][sm2];
        opy[3] = col2_reg[3][sm2];
        opy[2] = col2_reg[1][sm2];
        opy[1] = hex1_reg ? col2_reg[1][sm3] : col2_reg[1][sm2];
        opy[0] = hex1_reg ? col2_reg[0][sm3] : col2_reg[0][sm2];
    end

    always_ff @(posedge clk)
    begin
        opx_reg <= opx;
        opz_reg <= opz;
        opy_reg <= opy;
        last2_reg <= last1_reg;
        last3_reg <= last2_reg;
        last4_reg <= last3_reg;
        last5_reg <= last4_reg;
    end

    // Stage 2: stencil sums. Stage 3: sign and magnitude. Stage 4: scale products.
    logic [2:0][36:0] sum_reg;
    logic [2:0][35:0] mag_reg;
    logic [2:0]       neg3_reg, neg4_reg;
    logic [2:0][31:0] scales;
    logic [2:0][63:0] lp_reg;
    logic [2:0][35:0] hp_reg;
    logic [36:0]      neg_sum [3];

    assign scales = {scale_z_reg, scale_y_reg, scale_x_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            neg_sum[i] = 37'(0) - sum_reg[i];
    end

    always_ff @(posedge clk)
    begin
        sum_reg[0] <= stencil(opx_reg[3], opx_reg[2], opx_reg[2],
                              opx_reg[1], opx_reg[1], opx_reg[0]);
        sum_reg[1] <= stencil(opy_reg[5], opy_reg[4], opy_reg[3],
                              opy_reg[2], opy_reg[1], opy_reg[0]);
        sum_reg[2] <= stencil(opz_reg[3], opz_reg[2], opz_reg[2],
                              opz_reg[1], opz_reg[1], opz_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            neg3_reg[i] <= sum_reg[i][36];
            mag_reg[i] <= sum_reg[i][36] ? neg_sum[i][35:0] : sum_reg[i][35:0];
            neg4_reg[i] <= neg3_reg[i];
            lp_reg[i] <= mag_reg[i][31:0] * scales[i];
            hp_reg[i] <= mag_reg[i][35:32] * scales[i];
        end
    end

    // Stage 5: round to nearest on the magnitude, then saturate.
    logic [64:0]      rnd [3];
    logic [45:0]      qv [3];
    logic [45:0]      qn [3];
    logic [2:0][31:0] gout;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = {1'b0, lp_reg[i]} + 65'h80_0000;
            qv[i] = 46'({hp_reg[i], 8'b0}) + 46'(rnd[i][64:24]);
            qn[i] = (qv[i] > 46'h8000_0000) ? 46'h8000_0000 : qv[i];
            if (neg4_reg[i])
                gout[i] = 32'(0) - qn[i][31:0];
            else
                gout[i] = (qv[i] > 46'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv[i][31:0];
        end
    end

    // Pipeline tokens: a1 for each accepted sample, v1 to v5 only for interior points.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            a1_reg <= acc;
            v1_reg <= acc && interior;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Result queue and the count of results owed downstream.
    result_t        res_q [RES_DEPTH];
    logic [FW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  fifo_cnt_reg, credit_reg;
    logic           pop;

    assign pop = grad_valid && !grad_stall;
    assign grad_valid = (fifo_cnt_reg != '0);
    assign sample_stall = (credit_reg >= CW'(RES_DEPTH));
    assign grad_x = res_q[rd_ptr_reg].gx;
    assign grad_y = res_q[rd_ptr_reg].gy;
    assign grad_z = res_q[rd_ptr_reg].gz;
    assign last_point = res_q[rd_ptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (v5_reg)
            res_q[wr_ptr_reg] <= '{gx: gout[0], gy: gout[1], gz: gout[2], last: last5_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fifo_cnt_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (v5_reg)
                wr_ptr_reg <= wr_ptr_reg + FW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FW'(1);
            if (v5_reg && !pop)
                fifo_cnt_reg <= fifo_cnt_reg + CW'(1);
            else if (!v5_reg && pop)
                fifo_cnt_reg <= fifo_cnt_reg - CW'(1);
            if ((acc && interior) && !pop)
                credit_reg <= credit_reg + CW'(1);
            else if (!(acc && interior) && pop)
                credit_reg <= credit_reg - CW'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (fifo_cnt_reg < CW'(RES_DEPTH)))
        else $error("result queue written while full");

    a_credit_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}) + int'(fifo_cnt_reg))
            == int'(credit_reg))
        else $error("owed result count does not match results in flight");

    a_stall_when_owed: assert property (@(posedge clk) disable iff (!rst_n)
        (credit_reg == CW'(RES_DEPTH)) |-> sample_stall)
        else $error("input open with the result queue fully committed");
`endif

endmodule
`default_nettype wire

// ----- tb/ggs4_checker.sv -----
`default_nettype none
module ggs4_checker
    import ggs4_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               sample_valid,
    input  wire logic               sample_stall,
    input  wire logic signed [31:0] sample,
    input  wire logic               grad_valid,
    input  wire logic               grad_stall,
    input  wire logic signed [31:0] grad_x,
    input  wire logic signed [31:0] grad_y,
    input  wire logic signed [31:0] grad_z,
    input  wire logic               last_point,
    output int                      mismatches,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN = MAX_DIM_DEF + 4;

    logic signed [31:0] planes [4][SPAN][SPAN];
    int unsigned px, py, pz;
    logic [6:0]  dim_x, dim_y, dim_z;
    logic        hex_mode;
    logic [31:0] k_x, k_y, k_z;
    result_t     owed_grads [$];

    function automatic int unsigned padded(logic [6:0] s);
        if (s == 0)
            return 5;
        if (s > MAX_DIM_DEF)
            return MAX_DIM_DEF + 4;
        return s + 4;
    endfunction

    function automatic longint tap(int unsigned x, int unsigned y, int unsigned z);
        return longint'(planes[x & 3][y][z]);
    endfunction

    function automatic longint diff5(longint m2, longint m1, longint p1, longint p2);
        return m2 - 8 * m1 + 8 * p1 - p2;
    endfunction

    // Rounds half away from zero on the magnitude, then saturates to Q16.16.
    function automatic logic [31:0] scaled(longint s, logic [31:0] k);
        logic        neg;
        logic [95:0] mag;
        logic [95:0] q;
        neg = s < 0;
        mag = neg ? 96'(-s) : 96'(s);
        q = (mag * {64'd0, k} + 96'd8388608) >> 24;
        if (!neg)
            return (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if (q > 96'h8000_0000)
            q = 96'h8000_0000;
        return 32'd0 - q[31:0];
    endfunction

    task automatic predict(logic signed [31:0] v);
        int unsigned ex, ey, ez, cx;
        longint sx, sy, sz;
        result_t r;
        ex = padded(dim_x);
        ey = padded(dim_y);
        ez = padded(dim_z);
        if (px >= 4 && px < ex && py >= 2 && py < ey - 2 && pz >= 2 && pz < ez - 2)
        begin
            cx = px - 2;
            sx = diff5(tap(px - 4, py, pz), tap(px - 3, py, pz), tap(px - 1, py, pz),
                       longint'(v));
            sz = diff5(tap(cx, py, pz - 2), tap(cx, py, pz - 1),
                       tap(cx, py, pz + 1), tap(cx, py, pz + 2));
            if (hex_mode)
                sy = tap(cx + 1, py - 2, pz)
                   - 4 * (tap(cx + 1, py - 1, pz) + tap(cx, py - 1, pz))
                   + 4 * (tap(cx, py + 1, pz) + tap(cx - 1, py + 1, pz))
                   - tap(cx - 1, py + 2, pz);
            else
                sy = diff5(tap(cx, py - 2, pz), tap(cx, py - 1, pz),
                           tap(cx, py + 1, pz), tap(cx, py + 2, pz));
            r.gx = scaled(sx, k_x);
            r.gy = scaled(sy, k_y);
            r.gz = scaled(sz, k_z);
            r.last = (px == ex - 1 && py == ey - 3 && pz == ez - 3);
            owed_grads.push_back(r);
        end
        planes[px & 3][py][pz] = v;
        pz++;
        if (pz >= ez)
        begin
            pz = 0;
            py++;
            if (py >= ey)
            begin
                py = 0;
                px++;
                if (px >= ex)
                    px = 0;
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            px = 0;
            py = 0;
            pz = 0;
            dim_x = SIZE_RST;
            dim_y = SIZE_RST;
            dim_z = SIZE_RST;
            hex_mode = LATTICE_RST;
            k_x = SCALE_RST;
            k_y = SCALE_RST;
            k_z = SCALE_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SIZE_X:  dim_x = cfg_data[6:0];
                    CFG_SIZE_Y:  dim_y = cfg_data[6:0];
                    CFG_SIZE_Z:  dim_z = cfg_data[6:0];
                    CFG_LATTICE: hex_mode = cfg_data[0];
                    CFG_SCALE_X: k_x = cfg_data;
                    CFG_SCALE_Y: k_y = cfg_data;
                    CFG_SCALE_Z: k_z = cfg_data;
                    default: ;
                endcase
            end
            if (grad_valid && !grad_stall)
            begin
                if (owed_grads.size() == 0)
                begin
                    $display("%0t: gradient transaction with none expected", $realtime);
                    mismatches++;
                end
                else
                begin
                    w = owed_grads.pop_front();
                    if (grad_x !== w.gx)
                        report("grad_x", grad_x, w.gx);
                    if (grad_y !== w.gy)
                        report("grad_y", grad_y, w.gy);
                    if (grad_z !== w.gz)
                        report("grad_z", grad_z, w.gz);
                    if (last_point !== w.last)
                        report("last_point", 32'(last_point), 32'(w.last));
                end
            end
            if (sample_valid && !sample_stall)
                predict(sample);
        end
        pending = owed_grads.size();
    end

endmodule
`default_nettype wire

// ----- tb/tb_grid_gradient_stencil_4th_order.sv -----
`default_nettype none
module tb_grid_gradient_stencil_4th_order;
    import ggs4_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [2:0] CFG_NONE = 3'd7;
    localparam int RANDOM_ITEMS = 950;

    typedef enum int { VAL_FULL, VAL_EXTREME, VAL_SMALL } value_style_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               sample_valid;
    logic               sample_stall;
    logic signed [31:0] sample;
    logic               grad_valid;
    logic               grad_stall;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               last_point;
    int                 mismatches;
    int                 pending;
    int                 cycles;
    int                 burst_left;
    int                 random_sent;

    grid_gradient_stencil_4th_order DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .grad_valid(grad_valid), .grad_stall(grad_stall),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .last_point(last_point)
    );

    ggs4_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .grad_valid(grad_valid), .grad_stall(grad_stall),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .last_point(last_point),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("grid_gradient_stencil_4th_order regression: fail");
            $finish;
        end
    end

    // The receiver steps through four stall patterns: none, light random, heavy random and a fixed duty pattern.
    always @(negedge clk)
    begin
        case ((cycles / 300) % 4)
            0: grad_stall <= 1'b0;
            1: grad_stall <= ($urandom_range(0, 9) < 3);
            2: grad_stall <= ($urandom_range(0, 9) < 7);
            default: grad_stall <= (cycles % 5) < 2;
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Size and lattice fields carry random upper bits that the block must drop.
    task automatic setup(logic [6:0] sx, logic [6:0] sy, logic [6:0] sz, logic hex,
                         logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
        write_reg(CFG_SIZE_X, {25'($urandom_range(0, 33554431)), sx});
        write_reg(CFG_SIZE_Y, {25'($urandom_range(0, 33554431)), sy});
        write_reg(CFG_SIZE_Z, {25'($urandom_range(0, 33554431)), sz});
        write_reg(CFG_LATTICE, {31'($urandom_range(0, 2147483647)), hex});
        write_reg(CFG_SCALE_X, kx);
        write_reg(CFG_SCALE_Y, ky);
        write_reg(CFG_SCALE_Z, kz);
    endtask

    function automatic logic [31:0] pick_value(value_style_t style);
        case (style)
            VAL_EXTREME:
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            VAL_SMALL: return $urandom_range(0, 262143) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom_range(0, 67108864);
        endcase
    endfunction

    task automatic push_sample(logic [31:0] v);
        if (burst_left == 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        else
            @(negedge clk);
        burst_left--;
        sample_valid <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Streams a whole padded grid so the position counters end back at the origin.
    task automatic send_grid(int ex, int ey, int ez, value_style_t style);
        int n;
        n = ex * ey * ez;
        for (int i = 0; i < n; i++)
            push_sample(pick_value(style));
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int sx, sy, sz;
        value_style_t st;
        cycles = 0;
        burst_left = 0;
        random_sent = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        grad_stall = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Saturation with extreme samples, both lattices, unit and maximum scales.
        setup(7'd1, 7'd1, 7'd1, 1'b0, SCALE_RST, SCALE_RST, SCALE_RST);
        send_grid(5, 5, 5, VAL_EXTREME);
        drain();
        setup(7'd2, 7'd2, 7'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_grid(6, 6, 6, VAL_EXTREME);
        drain();
        // Zero sizes act as one, and a write past the register list is dropped.
        setup(7'd0, 7'd0, 7'd0, 1'b0, 32'd0, SCALE_RST, 32'd0);
        write_reg(CFG_NONE, 32'h0000_0003);
        send_grid(5, 5, 5, VAL_FULL);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            sx = $urandom_range(1, 4);
            sy = $urandom_range(1, 4);
            sz = $urandom_range(1, 6);
            st = value_style_t'($urandom_range(0, 2));
            setup(7'(sx), 7'(sy), 7'(sz), 1'($urandom_range(0, 1)),
                  pick_scale(), pick_scale(), pick_scale());
            send_grid(sx + 4, sy + 4, sz + 4, st);
            random_sent += (sx + 4) * (sy + 4) * (sz + 4);
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("grid_gradient_stencil_4th_order regression: pass");
        else
            $display("grid_gradient_stencil_4th_order regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
